// ===== rtl/core/icmpfsc_pkg.sv =====
// Shared types and constants of the ICMP flood source counter.
`timescale 1ns / 1ps
package icmpfsc_pkg;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned LEN_W       = 14;
    localparam int unsigned ETYPE_W     = 16;
    localparam int unsigned PROTO_W     = 8;
    localparam int unsigned THRESH_W    = 32;
    localparam int unsigned INTERVAL_W  = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [LEN_W-1:0]   MIN_FRAME_BYTES = LEN_W'(42);
    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_ICMP      = 8'd1;
    localparam logic [31:0]        HASH_MULT       = 32'h9E37_79B1;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

    localparam logic [THRESH_W-1:0]   THRESH_RESET   = THRESH_W'(1000);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = CFG_IDX_W'(1);

    // One way of a table set
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  key;
        logic [COUNT_W-1:0] count;
    } t_way;
endpackage

// ===== rtl/core/icmpfsc_pkt_if.sv =====
// Packet header channel.
`timescale 1ns / 1ps
interface icmpfsc_pkt_if;
    logic                            valid;
    logic                            ready;
    logic [icmpfsc_pkg::LEN_W-1:0]   frame_length;
    logic [icmpfsc_pkg::ETYPE_W-1:0] ether_type;
    logic [icmpfsc_pkg::PROTO_W-1:0] ip_protocol;
    logic [icmpfsc_pkg::ADDR_W-1:0]  source_address;

    modport source (output valid, frame_length, ether_type, ip_protocol,
                    source_address, input ready);
    modport sink (input valid, frame_length, ether_type, ip_protocol,
                  source_address, output ready);
endinterface

// ===== rtl/core/icmpfsc_evt_if.sv =====
// Flood event channel.
`timescale 1ns / 1ps
interface icmpfsc_evt_if;
    logic                            valid;
    logic                            ready;
    logic [icmpfsc_pkg::ADDR_W-1:0]  flagged_address;
    logic [icmpfsc_pkg::COUNT_W-1:0] flagged_count;

    modport source (output valid, flagged_address, flagged_count, input ready);
    modport sink (input valid, flagged_address, flagged_count, output ready);
endinterface

// ===== rtl/core/icmp_flood_source_counter_top.sv =====
// ICMP flood source counter: hashed per-source packet table with event output.
// A header is taken only while the block is idle. A header that is not a
// counted ICMP frame is consumed and the block stays idle. A counted one
// passes through accept, hash multiply, set reduction by reciprocal
// multiplication and one correction, table read and read-modify-write; it
// ends there when the source is inserted, dropped on a full set or hits a
// count at or below the threshold. A hit above the threshold then reckons
// the count modulo the interval, 8 bits per cycle, and if the count is a
// multiple of the interval emits an event, which waits for the output
// register. The table is one synchronous memory of TABLE_ENTRIES/TABLE_WAYS
// rows, one row per set; after reset a clearing pass empties it row by row,
// during which no header is taken. Configuration writes apply at once.
`timescale 1ns / 1ps
module icmp_flood_source_counter_top #(
    parameter int unsigned TABLE_ENTRIES = 1024,
    parameter int unsigned TABLE_WAYS    = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [icmpfsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [icmpfsc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    icmpfsc_pkt_if.sink                         i_pkt,
    icmpfsc_evt_if.source                       o_evt
);
    localparam int unsigned SETS  = TABLE_ENTRIES / TABLE_WAYS;
    localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned REM_W = SET_W + 1;
    localparam int unsigned DREM_W = icmpfsc_pkg::INTERVAL_W + 1;
    localparam int unsigned WAY_W = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    // floor(2^32 / SETS): quotient estimate is low by at most one
    localparam logic [32:0] SET_RECIP = 33'((64'd1 << 32) / 64'(SETS));

    typedef icmpfsc_pkg::t_way [TABLE_WAYS-1:0] t_row;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_SETMOD, ST_READ, ST_LOOKUP, ST_DIV, ST_EMIT
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [icmpfsc_pkg::THRESH_W-1:0]   r_threshold;
    logic [icmpfsc_pkg::INTERVAL_W-1:0] r_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= icmpfsc_pkg::THRESH_RESET;
            r_interval  <= icmpfsc_pkg::INTERVAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                icmpfsc_pkg::CFG_COUNT_THRESHOLD: begin
                    r_threshold <= i_cfg_data[icmpfsc_pkg::THRESH_W-1:0];
                end
                icmpfsc_pkg::CFG_SAMPLE_INTERVAL: begin
                    r_interval <= i_cfg_data[icmpfsc_pkg::INTERVAL_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Working registers
    logic [icmpfsc_pkg::ADDR_W-1:0]  r_addr, n_addr;
    logic [31:0]                     r_hash, n_hash;
    logic [31:0]                     r_quot, n_quot;
    logic [1:0]                      r_step, n_step;
    logic [REM_W-1:0]                r_srem, n_srem;
    logic [SET_W-1:0]                r_set, n_set;
    logic [SET_W-1:0]                r_clr, n_clr;
    logic [icmpfsc_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic [DREM_W-1:0]               r_drem, n_drem;
    logic                            r_out_valid, n_out_valid;
    logic [icmpfsc_pkg::ADDR_W-1:0]  r_out_addr, n_out_addr;
    logic [icmpfsc_pkg::COUNT_W-1:0] r_out_cnt, n_out_cnt;

    // Table memory
    t_row             mem [SETS];
    t_row             r_rd_row;
    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    t_row             mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_row <= mem[r_set];
    end

    // Packet filter
    logic pkt_take, pkt_counted;
    assign pkt_take    = i_pkt.valid && i_pkt.ready;
    assign pkt_counted = (i_pkt.frame_length >= icmpfsc_pkg::MIN_FRAME_BYTES)
                      && (i_pkt.ether_type == icmpfsc_pkg::ETHERTYPE_IPV4)
                      && (i_pkt.ip_protocol == icmpfsc_pkg::PROTO_ICMP);

    // Set reduction: reciprocal quotient, remainder estimate, one correction
    logic [31:0]      mixed, srem_est;
    logic [64:0]      quot_prod;
    logic [REM_W-1:0] srem_fix;
    always_comb begin
        mixed     = r_hash ^ (r_hash >> 16);
        quot_prod = {33'd0, mixed} * {32'd0, SET_RECIP};
        srem_est  = mixed - r_quot * 32'(SETS);
        srem_fix  = (r_srem >= REM_W'(SETS)) ? r_srem - REM_W'(SETS) : r_srem;
    end

    // Count modulo interval: 8 bits per cycle, zero interval taken as 1
    logic [DREM_W-1:0]               divisor, drem_acc;
    logic [icmpfsc_pkg::COUNT_W-1:0] cnt_sh;
    always_comb begin
        divisor  = (r_interval == '0) ? DREM_W'(1) : {1'b0, r_interval};
        cnt_sh   = r_cnt << {r_step, 3'b000};
        drem_acc = r_drem;
        for (int b = 0; b < 8; b++) begin
            drem_acc = {drem_acc[DREM_W-2:0], cnt_sh[31-b]};
            if (drem_acc >= divisor) begin
                drem_acc = drem_acc - divisor;
            end
        end
    end

    // Way search on the read row
    logic                            hit, have_free;
    logic [WAY_W-1:0]                hit_way, free_way;
    logic [icmpfsc_pkg::COUNT_W-1:0] hit_cnt, cnt_inc;
    always_comb begin
        hit       = 1'b0;
        have_free = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
            if (r_rd_row[w].valid && r_rd_row[w].key == r_addr) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!r_rd_row[w].valid) begin
                have_free = 1'b1;
                free_way  = WAY_W'(w);
            end
        end
        hit_cnt = r_rd_row[hit_way].count;
        cnt_inc = (hit_cnt == icmpfsc_pkg::COUNT_MAX) ? hit_cnt : hit_cnt + 1'b1;
    end

    // Next state and memory write
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_hash      = r_hash;
        n_quot      = r_quot;
        n_step      = r_step;
        n_srem      = r_srem;
        n_set       = r_set;
        n_clr       = r_clr;
        n_cnt       = r_cnt;
        n_drem      = r_drem;
        n_out_valid = r_out_valid && !o_evt.ready;
        n_out_addr  = r_out_addr;
        n_out_cnt   = r_out_cnt;
        mem_we      = 1'b0;
        mem_waddr   = r_set;
        mem_wdata   = r_rd_row;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == SET_W'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pkt_take && pkt_counted) begin
                    n_addr  = i_pkt.source_address;
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                n_hash  = r_addr * icmpfsc_pkg::HASH_MULT;
                n_step  = '0;
                n_srem  = '0;
                n_state = ST_SETMOD;
            end
            ST_SETMOD: begin
                n_step = r_step + 1'b1;
                if (r_step == 2'd0) begin
                    n_quot = quot_prod[63:32];
                end else if (r_step == 2'd1) begin
                    n_srem = srem_est[REM_W-1:0];
                end else begin
                    n_set   = srem_fix[SET_W-1:0];
                    n_step  = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                n_state = ST_IDLE;
                if (hit) begin
                    mem_we                   = 1'b1;
                    mem_wdata[hit_way].count = cnt_inc;
                    n_cnt                    = cnt_inc;
                    if (cnt_inc > r_threshold) begin
                        n_step  = '0;
                        n_drem  = '0;
                        n_state = ST_DIV;
                    end
                end else if (have_free) begin
                    mem_we                    = 1'b1;
                    mem_wdata[free_way].valid = 1'b1;
                    mem_wdata[free_way].key   = r_addr;
                    mem_wdata[free_way].count = icmpfsc_pkg::COUNT_W'(1);
                end
            end
            ST_DIV: begin
                n_drem = drem_acc;
                n_step = r_step + 1'b1;
                if (r_step == 2'd3) begin
                    n_state = (drem_acc == '0) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_evt.ready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_addr;
                    n_out_cnt   = r_cnt;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_step      <= '0;
            r_set       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_step      <= n_step;
            r_set       <= n_set;
            r_out_valid <= n_out_valid;
        end
        r_addr     <= n_addr;
        r_hash     <= n_hash;
        r_quot     <= n_quot;
        r_srem     <= n_srem;
        r_cnt      <= n_cnt;
        r_drem     <= n_drem;
        r_out_addr <= n_out_addr;
        r_out_cnt  <= n_out_cnt;
    end

    assign i_pkt.ready           = (r_state == ST_IDLE);
    assign o_evt.valid           = r_out_valid;
    assign o_evt.flagged_address = r_out_addr;
    assign o_evt.flagged_count   = r_out_cnt;

    // No header is taken during the clearing pass
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_pkt.ready)
        else $error("header taken during table clear");

    // A new event is only loaded from the emit state
    a_evt_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || o_evt.ready) ##1 r_out_valid |-> $past(r_state) == ST_EMIT)
        else $error("event loaded outside emit state");

    // An emitted count is never zero
    a_evt_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_cnt != '0)
        else $error("event with zero count");
endmodule
